>>> design/ssfp_pkg.sv
// types and constants for the substring search from position block
package ssfp_pkg;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;
    localparam int MATCH_END_W = 32;

    localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
    localparam logic [1:0] REG_START_POSITION = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic                   found;
        logic [MATCH_END_W-1:0] match_end;
    } t_out_item;

endpackage

>>> design/substring_search_from_position.sv
// top level of the substring search from position block
// Text bytes stream in one transaction per cycle while the input does not stall, the last byte of
// a string flagged. Each byte lands in an input register; from there it is shifted into a window
// of the most recent MAX_PATTERN bytes, every candidate pattern length is compared against the
// window in parallel, and the first match that starts at or after start_position is latched. On
// the flagged byte one result (found, match_end) goes from the input register to an output
// register once that is free, and the per-string state clears for the next string. Throughput is
// one byte per cycle, set by the combinational window compare; the input side only stalls while a
// result waits to be taken and the next flagged byte needs the output register. Configuration sits
// on a 64-bit APB port: pattern_bytes at 0x00, pattern_length at 0x08, start_position at 0x10;
// write only while idle.
module substring_search_from_position #(
    parameter int MAX_PATTERN   = 8,
    parameter int POSITION_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  ssfp_pkg::t_in_item             i_in_data,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output ssfp_pkg::t_out_item            o_out_data,
    input  logic                           i_out_stall,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssfp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ssfp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ssfp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int CW = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    logic [63:0]              r_pattern;
    logic [3:0]               r_length;
    logic [31:0]              r_start;

    logic                     r_in_valid;
    ssfp_pkg::t_in_item       r_in;

    logic [7:0]               r_win [MAX_PATTERN];
    logic [7:0]               n_win [MAX_PATTERN];
    logic [POSITION_BITS-1:0] r_count;
    logic                     r_seen;
    logic [POSITION_BITS-1:0] r_mend;

    logic                     r_out_valid;
    ssfp_pkg::t_out_item      r_out;

    logic                     cfg_we;
    logic [1:0]               cfg_idx;
    logic                     out_free;
    logic                     proc;
    logic                     in_take;
    logic [3:0]               len_eff;
    logic [POSITION_BITS-1:0] end_pos;
    logic [CW:0]              thresh;
    logic                     pos_ok;
    logic                     win_hit;
    logic                     eq;
    logic                     hit;
    logic                     found_now;
    logic [POSITION_BITS-1:0] mend_now;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[ssfp_pkg::APB_ADDR_W-1:3];
    assign cfg_we  = psel && penable && pwrite;

    always_comb begin
        unique case (cfg_idx)
            ssfp_pkg::REG_PATTERN_BYTES:  prdata = r_pattern;
            ssfp_pkg::REG_PATTERN_LENGTH: prdata = {60'd0, r_length};
            ssfp_pkg::REG_START_POSITION: prdata = {32'd0, r_start};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= '0;
            r_length  <= '0;
            r_start   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                ssfp_pkg::REG_PATTERN_BYTES:  r_pattern <= pwdata;
                ssfp_pkg::REG_PATTERN_LENGTH: r_length  <= pwdata[3:0];
                ssfp_pkg::REG_START_POSITION: r_start   <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && (!r_in.last_byte || out_free);
    assign o_in_stall = r_in_valid && !proc;
    assign in_take    = i_in_valid && !o_in_stall;

    // window compare
    assign len_eff = (r_length > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : r_length;
    assign end_pos = (&r_count) ? r_count : r_count + POSITION_BITS'(1);
    assign thresh  = (CW+1)'(r_start) + (CW+1)'(len_eff);
    assign pos_ok  = ((CW+1)'(end_pos) >= thresh) && (len_eff != 4'd0);

    always_comb begin
        n_win[0] = r_in.text_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    always_comb begin
        win_hit = 1'b0;
        eq      = 1'b1;
        for (int l = 1; l <= MAX_PATTERN; l++) begin
            eq = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (n_win[l-1-j] != r_pattern[8*j +: 8]) begin
                    eq = 1'b0;
                end
            end
            if (eq && (len_eff == 4'(l))) begin
                win_hit = 1'b1;
            end
        end
    end

    assign hit       = !r_seen && pos_ok && win_hit;
    assign found_now = r_seen || hit;
    assign mend_now  = r_seen ? r_mend : (hit ? end_pos : '0);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // per-string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_PATTERN; k++) begin
                r_win[k] <= '0;
            end
            r_count <= '0;
            r_seen  <= 1'b0;
            r_mend  <= '0;
        end else if (proc) begin
            if (r_in.last_byte) begin
                for (int k = 0; k < MAX_PATTERN; k++) begin
                    r_win[k] <= '0;
                end
                r_count <= '0;
                r_seen  <= 1'b0;
                r_mend  <= '0;
            end else begin
                r_win   <= n_win;
                r_count <= end_pos;
                if (hit) begin
                    r_seen <= 1'b1;
                    r_mend <= end_pos;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in.last_byte) begin
            r_out.found     <= found_now;
            r_out.match_end <= ssfp_pkg::MATCH_END_W'(mend_now);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    a_stall_only_when_holding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with empty input register");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc && r_in.last_byte |=> (r_count == '0) && !r_seen)
        else $error("string state not cleared after last byte");

    a_mend_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |-> (r_mend <= r_count) && (r_mend != '0))
        else $error("latched match end beyond byte count");

    a_no_found_zero_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.found |-> (r_out.match_end == '0))
        else $error("match end nonzero without a match");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |-> !(proc && r_in.last_byte))
        else $error("pending result overwritten");

endmodule

>>> tb/substring_search_from_position_tb.sv
// testbench for substring_search_from_position: streams text, checks each search result
module substring_search_from_position_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PATTERN = 8;
    localparam int HOLD_CYCLES = 80;
    localparam int QUIET_LIMIT = 3000;
    localparam int TARGET_BYTES = 520;
    localparam int DRAIN_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    ssfp_pkg::t_in_item in_data = '0;
    logic in_stall;
    logic out_valid;
    ssfp_pkg::t_out_item out_data;
    logic out_stall = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ssfp_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [ssfp_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [ssfp_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    bit sender_gaps = 1'b1;
    bit receiver_gaps = 1'b1;
    bit long_hold_req = 1'b0;
    int bytes_sent = 0;

    // tracks the search state and the queue of expected search results
    class match_scoreboard;
        logic [63:0] pattern_bytes;
        logic [3:0] pattern_length;
        logic [31:0] start_position;
        logic [7:0] window [MAX_PATTERN];
        logic [31:0] byte_count;
        logic match_seen;
        logic [31:0] first_end;
        ssfp_pkg::t_out_item expected_results[$];
        int errors;

        function new();
            pattern_bytes = '0;
            pattern_length = '0;
            start_position = '0;
            errors = 0;
            clear_string();
        endfunction

        function void clear_string();
            foreach (window[k]) window[k] = '0;
            byte_count = '0;
            match_seen = 1'b0;
            first_end = '0;
        endfunction

        function void set_register(logic [1:0] idx, logic [63:0] value);
            case (idx)
                ssfp_pkg::REG_PATTERN_BYTES: pattern_bytes = value;
                ssfp_pkg::REG_PATTERN_LENGTH: pattern_length = value[3:0];
                ssfp_pkg::REG_START_POSITION: start_position = value[31:0];
                default: ;
            endcase
        endfunction

        function int span();
            return (pattern_length > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_length);
        endfunction

        function void note_input(ssfp_pkg::t_in_item it);
            int len;
            bit same;
            ssfp_pkg::t_out_item res;
            len = span();
            for (int k = MAX_PATTERN - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = it.text_byte;
            if (byte_count != 32'hFFFF_FFFF) byte_count = byte_count + 1;
            if (!match_seen && len > 0 && byte_count >= len
                && byte_count - len >= start_position) begin
                same = 1'b1;
                for (int j = 0; j < len; j++) begin
                    if (window[len-1-j] != pattern_bytes[8*j +: 8]) same = 1'b0;
                end
                if (same) begin
                    match_seen = 1'b1;
                    first_end = byte_count;
                end
            end
            if (it.last_byte) begin
                res.found = match_seen;
                res.match_end = match_seen ? first_end : '0;
                expected_results.push_back(res);
                clear_string();
            end
        endfunction

        function void check_result(ssfp_pkg::t_out_item got);
            ssfp_pkg::t_out_item want;
            if (expected_results.size() == 0) begin
                $error("unexpected result: found %0d match_end %0d", got.found, got.match_end);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                errors++;
            end
            if (got.match_end !== want.match_end) begin
                $error("match_end: expected %0d, actual %0d", want.match_end, got.match_end);
                errors++;
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    match_scoreboard book = new();

    substring_search_from_position DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in_valid(in_valid),
        .i_in_data(in_data),
        .o_in_stall(in_stall),
        .o_out_valid(out_valid),
        .o_out_data(out_data),
        .i_out_stall(out_stall),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: accept, then pick the stall for the next cycle
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) book.check_result(out_data);
            if (hold_left > 0) begin
                hold_left--;
            end else if (long_hold_req) begin
                hold_left = HOLD_CYCLES;
                long_hold_req = 1'b0;
            end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(1, 14);
            end
            out_stall <= (hold_left > 0);
        end
    end

    // watchdog on cycles with no transaction on any port
    always @(posedge clk) begin
        static int quiet = 0;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("substring_search_from_position_tb failed");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        book.set_register(idx, value);
    endtask

    task automatic configure(input logic [63:0] pat, input logic [3:0] len,
                             input logic [31:0] start);
        write_reg(ssfp_pkg::REG_PATTERN_BYTES, pat);
        write_reg(ssfp_pkg::REG_PATTERN_LENGTH, {60'd0, len});
        write_reg(ssfp_pkg::REG_START_POSITION, {32'd0, start});
    endtask

    task automatic send_byte(input ssfp_pkg::t_in_item it);
        if (sender_gaps && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        book.note_input(it);
        bytes_sent++;
    endtask

    task automatic send_text(input logic [7:0] text[$]);
        ssfp_pkg::t_in_item it;
        foreach (text[k]) begin
            it.text_byte = text[k];
            it.last_byte = (k == text.size() - 1);
            send_byte(it);
        end
    endtask

    // sender stops until every search result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0) return 8'($urandom_range(1, 255));
        if (sel < 4) return 8'(8'h61 + $urandom_range(0, 2));
        return book.pattern_bytes[8*$urandom_range(0, 7) +: 8];
    endfunction

    task automatic send_random_string();
        logic [7:0] text[$];
        int n;
        int len;
        int off;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        len = book.span();
        for (int k = 0; k < n; k++) text.push_back(pick_byte());
        if (len > 0 && n >= len && $urandom_range(0, 3) != 0) begin
            off = $urandom_range(0, n - len);
            for (int j = 0; j < len; j++) text[off+j] = book.pattern_bytes[8*j +: 8];
        end
        send_text(text);
    endtask

    task automatic random_config();
        logic [63:0] pat;
        logic [3:0] len;
        logic [31:0] start;
        pat = {$urandom, $urandom};
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if ($urandom_range(0, 2) != 0) pat[8*j +: 8] = 8'(8'h61 + $urandom_range(0, 2));
        end
        case ($urandom_range(0, 9))
            0: len = 4'd0;
            1: len = 4'($urandom_range(9, 15));
            default: len = 4'($urandom_range(1, 8));
        endcase
        case ($urandom_range(0, 7))
            0: start = $urandom;
            1: start = 32'hFFFF_FFFF;
            default: start = $urandom_range(0, 12);
        endcase
        configure(pat, len, start);
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern after reset never matches
        send_text('{8'h41});
        drain();
        configure(64'h0000_0000_0063_6261, 4'd3, 32'd0);
        send_text('{8'h61, 8'h62});
        send_text('{8'h78, 8'h61, 8'h62, 8'h63, 8'h61});
        drain();
        // start position skips the first occurrence
        write_reg(ssfp_pkg::REG_START_POSITION, 64'd2);
        send_text('{8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63});
        drain();
        // length above the window size, all-ones pattern
        configure(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'd0);
        send_text('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
        drain();
        // zero byte compared like any other
        configure(64'd0, 4'd1, 32'd0);
        send_text('{8'h01, 8'h00});
        drain();
        write_reg(ssfp_pkg::REG_START_POSITION, 64'hFFFF_FFFF);
        send_text('{8'h01, 8'h00});
        drain();

        // receiver holds off while one-byte strings pile up
        configure(64'h61, 4'd1, 32'd0);
        long_hold_req = 1'b1;
        repeat (40) send_text('{8'($urandom_range(0, 1) ? 8'h61 : 8'h62)});
        drain();

        while (bytes_sent < TARGET_BYTES) begin
            if (bytes_sent > TARGET_BYTES - 90) begin
                sender_gaps = 1'b0;
                receiver_gaps = 1'b0;
            end
            random_config();
            repeat ($urandom_range(3, 8)) begin
                if (sender_gaps && $urandom_range(0, 9) == 0) drain();
                send_random_string();
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0) begin
            $display("substring_search_from_position_tb passed");
        end else begin
            $display("substring_search_from_position_tb failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/ssfp_pkg.sv
design/substring_search_from_position.sv
tb/substring_search_from_position_tb.sv
